FILE: rtl/core/stereo_windowed_rms_meter_assert.svh
// Assertion macros shared by the stereo RMS meter RTL.
`ifndef STEREO_WINDOWED_RMS_METER_ASSERT_SVH
`define STEREO_WINDOWED_RMS_METER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define SWRM_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SWRM_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SWRM_ASSERT_NOW(label, ck, rstn, ante, cons, msg)
`define SWRM_ASSERT_NEXT(label, ck, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/core/swrm_pkg.sv
// Shared constants and types of the stereo windowed RMS meter.
`timescale 1ns / 1ps
`default_nettype none

package swrm_pkg;

	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned SQ_W        = 2 * SAMPLE_BITS;
	localparam int unsigned QUO_W       = SQ_W;
	localparam int unsigned ROOT_STEPS  = QUO_W / 2;
	localparam int unsigned LEVEL_W     = SAMPLE_BITS;
	localparam int unsigned SUM_W       = 56;
	localparam int unsigned CNT_W       = 24;
	localparam int unsigned TOTAL_W     = 32;
	localparam int unsigned WF_W        = 18;
	localparam int unsigned CH_W        = 4;
	localparam int unsigned CTR_W       = $clog2(QUO_W + 1);

	localparam int unsigned MAX_WINDOW   = 131072;
	localparam int unsigned WF_RESET     = 48000;
	localparam int unsigned CH_RESET     = 2;
	localparam int unsigned MIN_CHANNELS = 2;

	localparam int unsigned S_TDATA_W = 2 * SAMPLE_BITS;
	localparam int unsigned M_USED_W  = 2 * LEVEL_W + TOTAL_W + CH_W;
	localparam int unsigned M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_WINDOW   = 1'b0;
	localparam logic REG_CHANNELS = 1'b1;

	typedef struct packed {
		logic load;
		logic square;
		logic accumulate;
		logic start;
	} lane_ctl_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] level;
	} lane_res_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] frame_total;
		logic               closed;
		logic [CH_W-1:0]    channels;
	} out_info_t;

endpackage

`default_nettype wire

FILE: rtl/core/stereo_windowed_rms_meter.sv
// Top level of the stereo windowed RMS meter: control, registers and two lanes.
//
//  Channel   Direction  Handshake                Contents
//  s_axis    in         tvalid/tready            tdata left, right sample; tlast buffer end
//  m_axis    out        tvalid/tready            tdata levels, total, channels; tuser closed
//  apb       in/out     psel/penable/pready      window_frames @0x0, channel_count @0x4
//
//  An ordinary request passes through capture, square, accumulate and output.
//  A request that closes a window also runs the 32-step restoring divider and
//  the 16-step floor root in each lane, between accumulate and output.
//  With fewer than two channels configured a request goes from capture to output.
//  arst_n clears control and accumulator state at once; no clearing pass is needed.
//  A stalled output holds its result while the next request is already taken in.
`timescale 1ns / 1ps
`default_nettype none

module stereo_windowed_rms_meter (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// s_axis_tdata: left_sample [15:0], right_sample [31:16]
	input  wire logic [swrm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input  wire logic                             s_axis_tlast,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// m_axis_tdata: left_meter [15:0], right_meter [31:16], total_frames [63:32],
	// channels_seen [67:64], zero pad
	output logic [swrm_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	// m_axis_tuser: window_closed
	output logic                                  m_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [swrm_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [swrm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [swrm_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready
);
	import swrm_pkg::*;

	// Control sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQ    = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_CALC  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]         state_q;
	logic               last_q;
	logic               closed_q;
	logic [CNT_W-1:0]   win_cnt_q;
	logic [TOTAL_W-1:0] frame_total_q;
	logic [WF_W-1:0]    window_frames_q;
	logic [CH_W-1:0]    channel_count_q;

	logic               accept;
	logic               chan_ok;
	logic               add_en;
	logic [CNT_W-1:0]   cnt_new;
	logic               close;
	logic               out_free;
	logic               push;
	logic               cfg_wr;
	logic               reg_idx;
	logic [WF_W-1:0]    wr_wf;

	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;

	lane_ctl_t ctl;
	lane_res_t l_res;
	lane_res_t r_res;
	out_info_t info;

	// ---------------------------------------------------------------
	// Configuration port: zero wait states, index from paddr[2]
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign wr_wf   = pwdata[WF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_frames_q <= WF_W'(WF_RESET);
			channel_count_q <= CH_W'(CH_RESET);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WINDOW: begin
					// Saturate the window length at the largest supported window
					window_frames_q <= (wr_wf > WF_W'(MAX_WINDOW)) ? WF_W'(MAX_WINDOW) : wr_wf;
				end
				REG_CHANNELS: begin
					channel_count_q <= pwdata[CH_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW:   prdata = APB_DATA_W'(window_frames_q);
			REG_CHANNELS: prdata = APB_DATA_W'(channel_count_q);
		endcase
	end

	// ---------------------------------------------------------------
	// Request intake and window bookkeeping
	// ---------------------------------------------------------------
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign chan_ok       = channel_count_q >= CH_W'(MIN_CHANNELS);
	assign left_sample   = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign right_sample  = $signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

	// Stop adding to the window once its count is full
	assign add_en  = (win_cnt_q != '1);
	assign cnt_new = add_en ? (win_cnt_q + CNT_W'(1)) : win_cnt_q;

	// Close only at a buffer end with enough frames in the window
	assign close = last_q && (cnt_new >= CNT_W'(window_frames_q)) && (cnt_new != '0);

	// The result register is free when empty or being drained this cycle
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign push     = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_q        <= 1'b0;
			closed_q      <= 1'b0;
			win_cnt_q     <= '0;
			frame_total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q   <= s_axis_tlast;
						closed_q <= 1'b0;
						// Skip the window update when fewer than two channels exist; a reading is still sent
						state_q  <= chan_ok ? ST_SQ : ST_OUT;
					end
				end
				ST_SQ: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					win_cnt_q <= cnt_new;
					if (frame_total_q != '1) begin
						frame_total_q <= frame_total_q + TOTAL_W'(1);
					end
					closed_q <= close;
					state_q  <= close ? ST_START : ST_OUT;
				end
				ST_START: begin
					// Lanes latch the count on this edge; clear the window behind them
					win_cnt_q <= '0;
					state_q   <= ST_CALC;
				end
				ST_CALC: begin
					if (l_res.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Lanes: left and right run in lockstep on the same controls
	// ---------------------------------------------------------------
	assign ctl.load       = accept;
	assign ctl.square     = (state_q == ST_SQ);
	assign ctl.accumulate = (state_q == ST_ACC) && add_en;
	assign ctl.start      = (state_q == ST_START);

	swrm_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (left_sample),
		.ctl    (ctl),
		.count  (win_cnt_q),
		.res    (l_res)
	);

	swrm_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (right_sample),
		.ctl    (ctl),
		.count  (win_cnt_q),
		.res    (r_res)
	);

	// ---------------------------------------------------------------
	// Merge: combine lane levels with totals into the result register
	// ---------------------------------------------------------------
	assign info.frame_total = frame_total_q;
	assign info.closed      = closed_q;
	assign info.channels    = channel_count_q;

	swrm_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.l_res         (l_res),
		.r_res         (r_res),
		.info          (info),
		.push          (push),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
`include "stereo_windowed_rms_meter_assert.svh"

	`SWRM_ASSERT_NOW(a_lanes_lockstep, clk, arst_n, l_res.done || r_res.done,
		l_res.done && r_res.done && (state_q == ST_CALC), "lanes finished out of step")
	`SWRM_ASSERT_NEXT(a_close_reported, clk, arst_n, (state_q == ST_CALC) && l_res.done,
		closed_q && (state_q == ST_OUT), "closed window not flagged")
	`SWRM_ASSERT_NEXT(a_total_monotonic, clk, arst_n, 1'b1,
		frame_total_q >= $past(frame_total_q), "frame total went backwards")
	`SWRM_ASSERT_NEXT(a_window_cleared, clk, arst_n, state_q == ST_START,
		win_cnt_q == '0, "window count not cleared at close")

endmodule

`default_nettype wire

FILE: rtl/core/swrm_lane.sv
// One channel lane: square, accumulate, then divide and floor root at window end.
`timescale 1ns / 1ps
`default_nettype none

module swrm_lane (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire logic signed [swrm_pkg::SAMPLE_BITS-1:0] sample,
	input  wire swrm_pkg::lane_ctl_t                 ctl,
	input  wire logic [swrm_pkg::CNT_W-1:0]          count,
	output swrm_pkg::lane_res_t                      res
);
	import swrm_pkg::*;

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_DIV  = 2'd1;
	localparam logic [1:0] L_ROOT = 2'd2;

	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SQ_W-1:0]        square_s2;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       sum_q;

	logic [1:0]       state_q;
	logic [CTR_W-1:0] ctr_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] div_q;
	logic [QUO_W-1:0] dvd_q;
	logic [QUO_W-1:0] root_q;
	logic [QUO_W-1:0] bit_q;
	logic             done_q;

	logic [CNT_W:0]   trial;
	logic             ge;
	logic [CNT_W:0]   diff;
	logic [QUO_W-1:0] root_try;
	logic             root_ge;

	assign mag     = smp_s1[SAMPLE_BITS-1] ? (~smp_s1 + SAMPLE_BITS'(1)) : smp_s1;
	assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(square_s2);

	// Restoring divide step: one quotient bit per cycle
	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// Floor root step on the quotient, two radicand bits per cycle
	assign root_try = root_q + bit_q;
	assign root_ge  = dvd_q >= root_try;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			smp_s1 <= $unsigned(sample);
		end
		if (ctl.square) begin
			square_s2 <= mag * mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			sum_q   <= '0;
			ctr_q   <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			dvd_q   <= '0;
			root_q  <= '0;
			bit_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			// Pulse done on the last root step
			done_q <= (state_q == L_ROOT) && (ctr_q == CTR_W'(1));
			if (ctl.accumulate) begin
				sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			end
			unique case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						rem_q   <= sum_q[SUM_W-1:QUO_W];
						dvd_q   <= sum_q[QUO_W-1:0];
						div_q   <= count;
						sum_q   <= '0;
						ctr_q   <= CTR_W'(QUO_W);
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
					dvd_q <= {dvd_q[QUO_W-2:0], ge};
					if (ctr_q == CTR_W'(1)) begin
						root_q  <= '0;
						bit_q   <= QUO_W'(1) << (QUO_W - 2);
						ctr_q   <= CTR_W'(ROOT_STEPS);
						state_q <= L_ROOT;
					end else begin
						ctr_q <= ctr_q - CTR_W'(1);
					end
				end
				L_ROOT: begin
					if (root_ge) begin
						dvd_q  <= dvd_q - root_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					ctr_q <= ctr_q - CTR_W'(1);
					if (ctr_q == CTR_W'(1)) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.level = root_q[LEVEL_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/swrm_merge.sv
// Merge stage: hold both lane levels and drive the result register.
`timescale 1ns / 1ps
`default_nettype none

module swrm_merge (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire swrm_pkg::lane_res_t              l_res,
	input  wire swrm_pkg::lane_res_t              r_res,
	input  wire swrm_pkg::out_info_t              info,
	input  wire logic                             push,
	// m_axis_tdata: left_meter, right_meter, total_frames, channels_seen, zero pad
	output logic [swrm_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	// m_axis_tuser: window_closed
	output logic                                  m_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready
);
	import swrm_pkg::*;

	logic [LEVEL_W-1:0] left_level_q;
	logic [LEVEL_W-1:0] right_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_level_q  <= '0;
			right_level_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (l_res.done && r_res.done) begin
				left_level_q  <= l_res.level;
				right_level_q <= r_res.level;
			end
			if (push) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_axis_tdata <= M_TDATA_W'({info.channels, info.frame_total,
				right_level_q, left_level_q});
			m_axis_tuser <= info.closed;
		end
	end

endmodule

`default_nettype wire

FILE: test/rms_reading_checker.sv
// Checker of the stereo RMS meter: predicts each reading and compares it with the block's.
`timescale 1ns / 1ps

module rms_reading_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [swrm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input  wire logic                             s_axis_tlast,
	input  wire logic                             s_axis_tvalid,
	input  wire logic                             s_axis_tready,
	input  wire logic [swrm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input  wire logic                             m_axis_tuser,
	input  wire logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [swrm_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [swrm_pkg::APB_DATA_W-1:0]  pwdata,
	input  wire logic                             pready,
	output int unsigned                           pending_readings,
	output int unsigned                           mismatch_count
);
	import swrm_pkg::*;

	localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 64'd1;
	localparam logic [CNT_W-1:0] WINDOW_FULL = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_FULL = '1;

	typedef struct packed {
		logic [LEVEL_W-1:0] left_meter;
		logic [LEVEL_W-1:0] right_meter;
		logic [TOTAL_W-1:0] total_frames;
		logic               window_closed;
		logic [CH_W-1:0]    channels_seen;
	} meter_reading_t;

	meter_reading_t expected_readings[$];

	logic [WF_W-1:0]    window_len;
	logic [CH_W-1:0]    chan_reg;
	logic [SUM_W-1:0]   left_acc;
	logic [SUM_W-1:0]   right_acc;
	logic [CNT_W-1:0]   frames_in_window;
	logic [TOTAL_W-1:0] frames_seen;
	logic [LEVEL_W-1:0] left_lvl;
	logic [LEVEL_W-1:0] right_lvl;

	function automatic longint unsigned square_of(input logic [SAMPLE_BITS-1:0] raw);
		longint v;
		v = signed'(raw);
		return longint'(v * v);
	endfunction

	function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] acc,
			input longint unsigned sq);
		longint unsigned s;
		s = longint'(acc) + sq;
		return (s > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s[SUM_W-1:0];
	endfunction

	// Largest root of a 56-bit sum fits in 28 bits.
	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned root;
		longint unsigned cand;
		root = 0;
		for (int b = 28; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= x)
				root = cand;
		end
		return root;
	endfunction

	function automatic meter_reading_t predict_reading(input logic [SAMPLE_BITS-1:0] l_raw,
			input logic [SAMPLE_BITS-1:0] r_raw, input logic buf_end);
		meter_reading_t rd;
		logic closed;
		closed = 1'b0;
		if (chan_reg >= CH_W'(MIN_CHANNELS)) begin
			if (frames_in_window != WINDOW_FULL) begin
				left_acc = add_clamped(left_acc, square_of(l_raw));
				right_acc = add_clamped(right_acc, square_of(r_raw));
				frames_in_window = frames_in_window + 1'b1;
			end
			if (frames_seen != TOTAL_FULL)
				frames_seen = frames_seen + 1'b1;
			if (buf_end && frames_in_window >= window_len && frames_in_window != 0) begin
				left_lvl = LEVEL_W'(root_floor(longint'(left_acc) / longint'(frames_in_window)));
				right_lvl = LEVEL_W'(root_floor(longint'(right_acc) / longint'(frames_in_window)));
				left_acc = '0;
				right_acc = '0;
				frames_in_window = '0;
				closed = 1'b1;
			end
		end
		rd.left_meter = left_lvl;
		rd.right_meter = right_lvl;
		rd.total_frames = frames_seen;
		rd.window_closed = closed;
		rd.channels_seen = chan_reg;
		return rd;
	endfunction

	task automatic compare_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	initial mismatch_count = 0;

	always @(posedge clk or negedge arst_n) begin
		meter_reading_t want;
		meter_reading_t got;
		logic [WF_W-1:0] wv;
		if (!arst_n) begin
			window_len = WF_W'(WF_RESET);
			chan_reg = CH_W'(CH_RESET);
			left_acc = '0;
			right_acc = '0;
			frames_in_window = '0;
			frames_seen = '0;
			left_lvl = '0;
			right_lvl = '0;
			expected_readings.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.left_meter = m_axis_tdata[LEVEL_W-1:0];
				got.right_meter = m_axis_tdata[2*LEVEL_W-1:LEVEL_W];
				got.total_frames = m_axis_tdata[2*LEVEL_W+TOTAL_W-1:2*LEVEL_W];
				got.channels_seen = m_axis_tdata[M_USED_W-1:2*LEVEL_W+TOTAL_W];
				got.window_closed = m_axis_tuser;
				if (expected_readings.size() == 0) begin
					$display("%0t: reading with no request outstanding, expected none, actual %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
					mismatch_count++;
				end else begin
					want = expected_readings.pop_front();
					compare_field("left_meter", want.left_meter, got.left_meter);
					compare_field("right_meter", want.right_meter, got.right_meter);
					compare_field("total_frames", want.total_frames, got.total_frames);
					compare_field("window_closed", want.window_closed, got.window_closed);
					compare_field("channels_seen", want.channels_seen, got.channels_seen);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_readings.push_back(predict_reading(s_axis_tdata[SAMPLE_BITS-1:0],
					s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], s_axis_tlast));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_WINDOW) begin
					wv = pwdata[WF_W-1:0];
					window_len = (wv > WF_W'(MAX_WINDOW)) ? WF_W'(MAX_WINDOW) : wv;
				end else begin
					chan_reg = pwdata[CH_W-1:0];
				end
			end
		end
		pending_readings = expected_readings.size();
	end

endmodule

FILE: test/tb_stereo_windowed_rms_meter.sv
// Top of the stereo RMS meter testbench: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_stereo_windowed_rms_meter;
	import swrm_pkg::*;

	// Quiet cycles allowed before the run is called hung.
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 500;
	// Longest the block needs to hand over a reading: divider plus root.
	localparam int TAIL_CYCLES = 60;

	logic                    clk;
	logic                    arst_n;
	// s_axis_tdata: left_sample [15:0], right_sample [31:16]
	logic [S_TDATA_W-1:0]    s_axis_tdata;
	logic                    s_axis_tlast;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	// m_axis_tdata: left_meter [15:0], right_meter [31:16], total_frames [63:32],
	// channels_seen [67:64], zero pad
	logic [M_TDATA_W-1:0]    m_axis_tdata;
	// m_axis_tuser: window_closed
	logic                    m_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;

	int unsigned pending_readings;
	int unsigned mismatch_count;

	// Idle odds, in percent, for each side; changed per phase.
	int send_idle_pct;
	int recv_idle_pct;
	// Channel count last written, to tell counted requests from ignored ones.
	int chans_now;

	stereo_windowed_rms_meter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	rms_reading_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_axis_tdata     (s_axis_tdata),
		.s_axis_tlast     (s_axis_tlast),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.m_axis_tuser     (m_axis_tuser),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.pready           (pready),
		.pending_readings (pending_readings),
		.mismatch_count   (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: decide afresh at every falling edge whether to take a reading.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: any accepted request, reading or register access resets the count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_stereo_windowed_rms_meter failed");
		$finish;
	end

	// Mostly full-range noise, with the extremes and quiet signals mixed in.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int sel;
		sel = $urandom_range(99);
		if (sel < 12) begin
			case ($urandom_range(4))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'h0000;
				3: return 16'hFFFF;
				default: return 16'h0001;
			endcase
		end
		if (sel < 27)
			return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
		return SAMPLE_BITS'($urandom);
	endfunction

	// Offer one request; hold it until the block takes it. Random idle cycles go
	// in front, with junk on the data lines while tvalid is low.
	task automatic push_frame(input logic [SAMPLE_BITS-1:0] left,
			input logic [SAMPLE_BITS-1:0] right, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= S_TDATA_W'($urandom);
			s_axis_tlast <= 1'($urandom_range(1));
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {right, left};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop tvalid and wait for every outstanding reading to come back.
	task automatic drain_readings();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_readings != 0)
			@(negedge clk);
	endtask

	// Setup phase, then access phase; the write lands once pready is seen.
	task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_CHANNELS)
			chans_now = int'(value[CH_W-1:0]);
	endtask

	// Both registers written only once the block has gone quiet.
	task automatic configure(input logic [APB_DATA_W-1:0] window,
			input logic [APB_DATA_W-1:0] chans);
		drain_readings();
		write_reg(REG_WINDOW, window);
		write_reg(REG_CHANNELS, chans);
	endtask

	initial begin : stimulus
		int fed;
		int seg_len;
		int seg_fed;
		int buf_len;
		int pick;
		logic well_formed;
		logic [APB_DATA_W-1:0] window_word;
		logic [APB_DATA_W-1:0] chan_word;

		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tvalid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		chans_now = int'(CH_RESET);
		send_idle_pct = 10;
		recv_idle_pct = 61;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: a buffer end far short of the window must not close it.
		push_frame(16'h8000, 16'h8000, 1'b1);
		push_frame(16'h7FFF, 16'h8000, 1'b1);

		// Fewer than two channels: frames pass through without touching the state.
		drain_readings();
		write_reg(REG_CHANNELS, 32'd0);
		push_frame(16'h7FFF, 16'h8000, 1'b1);
		drain_readings();
		write_reg(REG_CHANNELS, 32'd1);
		push_frame(16'h1234, 16'hFFFF, 1'b1);

		// Zero window: every buffer end closes, including full-scale negative.
		configure(32'd0, 32'd2);
		push_frame(16'h8000, 16'h8000, 1'b1);
		push_frame(16'h7FFF, 16'h7FFF, 1'b1);
		push_frame(16'h0000, 16'h0000, 1'b1);
		push_frame(16'hFFFF, 16'h0001, 1'b1);

		// Window of three with junk in the upper bits; an early buffer end holds.
		configure(32'hFFFC_0003, 32'hFFFF_FFF8);
		push_frame(16'd1000, 16'hFC18, 1'b1);
		push_frame(16'd300, 16'd400, 1'b0);
		push_frame(16'h8000, 16'h7FFF, 1'b1);

		// Windows above the ceiling clamp to it; channel count at its top code.
		configure(32'h0003_FFFF, 32'd15);
		push_frame(16'd5, 16'd5, 1'b1);
		configure(32'd131073, 32'd8);
		push_frame(16'hFFFB, 16'd5, 1'b1);
		configure(32'd131072, 32'd2);
		push_frame(16'd7, 16'd9, 1'b1);

		// Window of one: closes on each buffer end, averaging what built up.
		configure(32'd1, 32'd3);
		push_frame(16'h4000, 16'hC000, 1'b1);
		push_frame(16'h0001, 16'h8000, 1'b0);
		push_frame(16'h7FFF, 16'h0000, 1'b1);

		// Random phases: sender mostly busy, then receiver, then neither idles.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			fed = 0;
			while (fed < RANDOM_PER_PHASE) begin
				// Mostly short windows so they close often; some full-range words.
				pick = $urandom_range(99);
				if (pick < 88)
					window_word = ($urandom & 32'hFFFC_0000) | $urandom_range(0, 24);
				else
					window_word = $urandom;
				pick = $urandom_range(99);
				if (pick < 85)
					chan_word = ($urandom & 32'hFFFF_FFF0) | $urandom_range(2, 8);
				else if (pick < 95)
					chan_word = ($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 1);
				else
					chan_word = ($urandom & 32'hFFFF_FFF0) | $urandom_range(9, 15);
				configure(window_word, chan_word);

				seg_len = (chans_now >= MIN_CHANNELS) ? $urandom_range(20, 80)
					: $urandom_range(4, 10);
				seg_fed = 0;
				while (seg_fed < seg_len) begin
					// Most buffers end cleanly on their last frame; the rest carry
					// buffer-end flags at random.
					buf_len = $urandom_range(1, 8);
					well_formed = ($urandom_range(99) < 85);
					for (int k = 0; k < buf_len; k++)
						push_frame(pick_sample(), pick_sample(),
							well_formed ? (k == buf_len - 1) : 1'($urandom_range(1)));
					seg_fed += buf_len;
				end
				if (chans_now >= MIN_CHANNELS)
					fed += seg_fed;
			end
		end

		// Wait out every reading, then a tail long enough to catch strays.
		drain_readings();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_stereo_windowed_rms_meter passed");
		else
			$display("tb_stereo_windowed_rms_meter failed");
		$finish;
	end

endmodule
